// ===== src/lpse_pkg.sv =====
package lpse_pkg;

   localparam int NUM_FIELDS          = 8;
   localparam int MAX_COMPONENTS_DEF  = 8;
   localparam int CSR_INDEX_W         = 2;
   localparam int CSR_DATA_W          = 8;
   localparam int COUNT_W             = 4;

   localparam logic [7:0] BIT_ONE_CODE  = 8'hF8;
   localparam logic [7:0] BIT_ZERO_CODE = 8'hC0;
   localparam logic [7:0] LATCH_CODE    = 8'h00;

   localparam logic [COUNT_W-1:0] COUNT_RESET      = 4'd3;
   localparam logic [7:0]         BRIGHTNESS_RESET = 8'd255;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_COMPONENT_COUNT   = 2'd0,
      CSR_GLOBAL_BRIGHTNESS = 2'd1
   } csr_index_type;

   typedef enum logic {
      OP_PIXEL = 1'b0,
      OP_LATCH = 1'b1
   } op_type;

   typedef struct packed {
      op_type                          op;
      logic [7:0]                      pixel_brightness;
      logic [NUM_FIELDS-1:0][7:0]      comp;
   } pixel_type;

   typedef struct packed {
      op_type                          op;
      logic [NUM_FIELDS-1:0][7:0]      comp;
   } scaled_type;

   // floor(x / 255), exact for x <= 255 * 255
   function automatic logic [7:0] div255(input logic [15:0] x);
      logic [16:0] t;
      t = {1'b0, x} + {9'd0, x[15:8]} + 17'd1;
      return t[15:8];
   endfunction

endpackage

// ===== src/lpse_if.sv =====
interface lpse_req_if;
   logic       valid;
   logic       ready;
   logic       op;
   logic [7:0] component_0;
   logic [7:0] component_1;
   logic [7:0] component_2;
   logic [7:0] component_3;
   logic [7:0] component_4;
   logic [7:0] component_5;
   logic [7:0] component_6;
   logic [7:0] component_7;
   logic [7:0] pixel_brightness;

   modport source (
      output valid, op, component_0, component_1, component_2, component_3,
             component_4, component_5, component_6, component_7, pixel_brightness,
      input  ready
   );
   modport sink (
      input  valid, op, component_0, component_1, component_2, component_3,
             component_4, component_5, component_6, component_7, pixel_brightness,
      output ready
   );
endinterface

interface lpse_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] spi_byte;
   logic       last_byte;

   modport source (output valid, spi_byte, last_byte, input ready);
   modport sink (input valid, spi_byte, last_byte, output ready);
endinterface

// ===== src/lpse_scale.sv =====
module lpse_scale #(
   parameter int MAX_COMPONENTS = lpse_pkg::MAX_COMPONENTS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  in_valid,
   output logic                  in_ready,
   input  lpse_pkg::pixel_type   in_item,
   input  logic [7:0]            global_brightness,
   output logic                  out_valid,
   input  logic                  out_ready,
   output lpse_pkg::scaled_type  out_item
);
   import lpse_pkg::*;

   logic v1_ff, v2_ff, v3_ff, v4_ff;
   logic en1, en2, en3, en4;

   op_type                        op1_ff, op2_ff, op3_ff, op4_ff;
   logic [NUM_FIELDS-1:0][7:0]    comp1_ff, comp2_ff, scaled4_ff, scaled4_in;
   logic [NUM_FIELDS-1:0][15:0]   prod3_ff, prod3_in;
   logic [15:0]                   bprod1_ff;
   logic [7:0]                    total2_ff;

   assign en4      = !v4_ff || out_ready;
   assign en3      = !v3_ff || en4;
   assign en2      = !v2_ff || en3;
   assign en1      = !v1_ff || en2;
   assign in_ready = en1;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
      end else begin
         if (en1) v1_ff <= in_valid;
         if (en2) v2_ff <= v1_ff;
         if (en3) v3_ff <= v2_ff;
         if (en4) v4_ff <= v3_ff;
      end
   end

   // per-lane scaling; lanes beyond MAX_COMPONENTS never reach the wire
   for (genvar g = 0; g < NUM_FIELDS; g++) begin : g_lane
      if (g < MAX_COMPONENTS) begin : g_used
         assign prod3_in[g]   = 16'(comp2_ff[g] * total2_ff);
         assign scaled4_in[g] = div255(prod3_ff[g]);
      end else begin : g_unused
         assign prod3_in[g]   = '0;
         assign scaled4_in[g] = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (en1) begin
         op1_ff    <= in_item.op;
         comp1_ff  <= in_item.comp;
         bprod1_ff <= 16'(in_item.pixel_brightness * global_brightness);
      end
      if (en2) begin
         op2_ff    <= op1_ff;
         comp2_ff  <= comp1_ff;
         total2_ff <= div255(bprod1_ff);
      end
      if (en3) begin
         op3_ff   <= op2_ff;
         prod3_ff <= prod3_in;
      end
      if (en4) begin
         op4_ff     <= op3_ff;
         scaled4_ff <= scaled4_in;
      end
   end

   assign out_valid     = v4_ff;
   assign out_item.op   = op4_ff;
   assign out_item.comp = scaled4_ff;

endmodule

// ===== src/lpse_serializer.sv =====
module lpse_serializer #(
   parameter int MAX_COMPONENTS = lpse_pkg::MAX_COMPONENTS_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            in_valid,
   output logic                            in_ready,
   input  lpse_pkg::scaled_type            in_item,
   input  logic [lpse_pkg::COUNT_W-1:0]    eff_count,
   output logic                            out_valid,
   input  logic                            out_ready,
   output logic [7:0]                      out_byte,
   output logic                            out_last
);
   import lpse_pkg::*;

   localparam int SH_W  = MAX_COMPONENTS * 8;
   localparam int CNT_W = $clog2(SH_W);

   logic               busy_ff;
   op_type             op_ff;
   logic [SH_W-1:0]    sh_ff, sh_load;
   logic [CNT_W-1:0]   rem_ff;
   logic               rsp_valid_ff;
   logic [7:0]         rsp_byte_ff;
   logic               rsp_last_ff;

   logic out_en, emit, last_now, load;
   logic [7:0] cur_byte;

   for (genvar g = 0; g < MAX_COMPONENTS; g++) begin : g_load
      assign sh_load[SH_W-1-8*g -: 8] = in_item.comp[g];
   end

   assign out_en   = !rsp_valid_ff || out_ready;
   assign emit     = busy_ff && out_en;
   assign last_now = (rem_ff == '0);
   assign in_ready = !busy_ff || (emit && last_now);
   assign load     = in_valid && in_ready;

   always_comb begin
      if (op_ff == OP_LATCH) begin
         cur_byte = LATCH_CODE;
      end else if (sh_ff[SH_W-1]) begin
         cur_byte = BIT_ONE_CODE;
      end else begin
         cur_byte = BIT_ZERO_CODE;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (load) begin
            busy_ff <= 1'b1;
         end else if (emit && last_now) begin
            busy_ff <= 1'b0;
         end
         if (out_en) rsp_valid_ff <= emit;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         op_ff <= in_item.op;
         sh_ff <= sh_load;
         if (in_item.op == OP_LATCH) begin
            rem_ff <= '0;
         end else begin
            rem_ff <= CNT_W'({eff_count - COUNT_W'(1), 3'b111});
         end
      end else if (emit) begin
         sh_ff  <= {sh_ff[SH_W-2:0], 1'b0};
         rem_ff <= rem_ff - CNT_W'(1);
      end
      if (emit) begin
         rsp_byte_ff <= cur_byte;
         rsp_last_ff <= last_now;
      end
   end

   assign out_valid = rsp_valid_ff;
   assign out_byte  = rsp_byte_ff;
   assign out_last  = rsp_last_ff;

endmodule

// ===== src/led_pixel_scale_and_spi_encode_unit.sv =====
// channel   dir   handshake        payload
// req_chan  in    valid/ready      op, component_0..7, pixel_brightness
// rsp_chan  out   valid/ready      spi_byte, last_byte
// csr_*     in    csr_we only      csr_index, csr_wdata
//
// A pixel gives 8 bytes per component (24 for three), one byte per cycle from the
// bit shifter while rsp_chan accepts; a latch gives one byte. The shifter is the rate limit.
// Data path: 4 scaling stages, a shifter load, one output register.
// Synchronous active-high reset; CSRs return to count 3, brightness 255.
// Back-pressure on rsp_chan stalls the shifter, then the scaling stages, then req_chan.
module led_pixel_scale_and_spi_encode_unit #(
   parameter int MAX_COMPONENTS = lpse_pkg::MAX_COMPONENTS_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   lpse_req_if.sink                            req_chan,
   lpse_rsp_if.source                          rsp_chan,
   input  logic                                csr_we,
   input  logic [lpse_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [lpse_pkg::CSR_DATA_W-1:0]     csr_wdata
);
   import lpse_pkg::*;

   logic [COUNT_W-1:0] count_ff;
   logic [7:0]         gbright_ff;
   logic [COUNT_W-1:0] eff_count;

   pixel_type  pix_item;
   scaled_type scaled_item;
   logic       scaled_valid, scaled_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff   <= COUNT_RESET;
         gbright_ff <= BRIGHTNESS_RESET;
      end else if (csr_we) begin
         unique case (csr_index_type'(csr_index))
            CSR_COMPONENT_COUNT:   count_ff   <= csr_wdata[COUNT_W-1:0];
            CSR_GLOBAL_BRIGHTNESS: gbright_ff <= csr_wdata[7:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      priority if (count_ff == '0) begin
         eff_count = COUNT_W'(1);
      end else if (count_ff > COUNT_W'(MAX_COMPONENTS)) begin
         eff_count = COUNT_W'(MAX_COMPONENTS);
      end else begin
         eff_count = count_ff;
      end
   end

   assign pix_item.op               = op_type'(req_chan.op);
   assign pix_item.pixel_brightness = req_chan.pixel_brightness;
   assign pix_item.comp = {req_chan.component_7, req_chan.component_6,
                           req_chan.component_5, req_chan.component_4,
                           req_chan.component_3, req_chan.component_2,
                           req_chan.component_1, req_chan.component_0};

   lpse_scale #(.MAX_COMPONENTS(MAX_COMPONENTS)) u_scale (
      .clock             (clock),
      .reset             (reset),
      .in_valid          (req_chan.valid),
      .in_ready          (req_chan.ready),
      .in_item           (pix_item),
      .global_brightness (gbright_ff),
      .out_valid         (scaled_valid),
      .out_ready         (scaled_ready),
      .out_item          (scaled_item)
   );

   lpse_serializer #(.MAX_COMPONENTS(MAX_COMPONENTS)) u_ser (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (scaled_valid),
      .in_ready  (scaled_ready),
      .in_item   (scaled_item),
      .eff_count (eff_count),
      .out_valid (rsp_chan.valid),
      .out_ready (rsp_chan.ready),
      .out_byte  (rsp_chan.spi_byte),
      .out_last  (rsp_chan.last_byte)
   );

   a_latch_is_last: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid && rsp_chan.spi_byte == LATCH_CODE |-> rsp_chan.last_byte)
      else $error("latch byte without last marker");

   a_byte_code: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid |-> (rsp_chan.spi_byte == BIT_ONE_CODE ||
                          rsp_chan.spi_byte == BIT_ZERO_CODE ||
                          rsp_chan.spi_byte == LATCH_CODE))
      else $error("illegal SPI byte code");

   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_chan.valid)
      else $error("response valid after reset");

   a_csr_gbright: assert property (@(posedge clock) disable iff (reset)
      csr_we && csr_index == CSR_GLOBAL_BRIGHTNESS |=> gbright_ff == $past(csr_wdata[7:0]))
      else $error("global brightness write lost");

endmodule

// ===== dv/lpse_spi_byte_checker.sv =====
module lpse_spi_byte_checker (
   input  logic                             clock,
   input  logic                             reset,
   lpse_req_if                              req_mon,
   lpse_rsp_if                              rsp_mon,
   input  logic                             csr_we,
   input  logic [lpse_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [lpse_pkg::CSR_DATA_W-1:0]  csr_wdata,
   output int                               fail_count,
   output int                               pending,
   output int                               bytes_checked
);
   timeunit 1ns;
   timeprecision 1ps;
   import lpse_pkg::*;

   localparam int FULL_SCALE = 255;

   typedef struct packed {
      logic [7:0] spi_byte;
      logic       last_byte;
   } spi_byte_type;

   spi_byte_type       expected_bytes[$];
   logic [COUNT_W-1:0] component_count = COUNT_RESET;
   logic [7:0]         global_brightness = BRIGHTNESS_RESET;
   int                 fails = 0;
   int                 checked = 0;

   function void note_failure(input string msg);
      fails++;
      $error("%s", msg);
   endfunction

   function void queue_spi_bytes(input op_type op, input logic [7:0] pix_b,
                                 input logic [NUM_FIELDS-1:0][7:0] comp);
      int           combined;
      int           scaled;
      int           n;
      spi_byte_type b;
      if (op == OP_LATCH) begin
         b.spi_byte  = LATCH_CODE;
         b.last_byte = 1'b1;
         expected_bytes.insert(expected_bytes.size(), b);
         return;
      end
      combined = (32'(pix_b) * 32'(global_brightness)) / FULL_SCALE;
      n = int'(component_count);
      if (n == 0) begin
         n = 1;
      end
      if (n > MAX_COMPONENTS_DEF) begin
         n = MAX_COMPONENTS_DEF;
      end
      for (int i = 0; i < n; i++) begin
         scaled = (32'(comp[i]) * combined) / FULL_SCALE;
         for (int k = 7; k >= 0; k--) begin
            b.spi_byte  = scaled[k] ? BIT_ONE_CODE : BIT_ZERO_CODE;
            b.last_byte = (i == n - 1) && (k == 0);
            expected_bytes.insert(expected_bytes.size(), b);
         end
      end
   endfunction

   always @(posedge clock) begin
      spi_byte_type want;
      if (reset) begin
         expected_bytes.delete();
         component_count   = COUNT_RESET;
         global_brightness = BRIGHTNESS_RESET;
      end else begin
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (expected_bytes.size() == 0) begin
               note_failure($sformatf("unexpected transaction: spi_byte %02h last_byte %0b",
                                      rsp_mon.spi_byte, rsp_mon.last_byte));
            end else begin
               want = expected_bytes.pop_front();
               checked++;
               if (rsp_mon.spi_byte !== want.spi_byte) begin
                  note_failure($sformatf("spi_byte: expected %02h, actual %02h",
                                         want.spi_byte, rsp_mon.spi_byte));
               end
               if (rsp_mon.last_byte !== want.last_byte) begin
                  note_failure($sformatf("last_byte: expected %0b, actual %0b",
                                         want.last_byte, rsp_mon.last_byte));
               end
            end
         end
         if (csr_we) begin
            case (csr_index)
               CSR_COMPONENT_COUNT: begin
                  component_count = csr_wdata[COUNT_W-1:0];
               end
               CSR_GLOBAL_BRIGHTNESS: begin
                  global_brightness = csr_wdata;
               end
               default: begin
               end
            endcase
         end
         if (req_mon.valid && req_mon.ready) begin
            queue_spi_bytes(op_type'(req_mon.op), req_mon.pixel_brightness,
                            {req_mon.component_7, req_mon.component_6,
                             req_mon.component_5, req_mon.component_4,
                             req_mon.component_3, req_mon.component_2,
                             req_mon.component_1, req_mon.component_0});
         end
      end
      fail_count    <= fails;
      pending       <= expected_bytes.size();
      bytes_checked <= checked;
   end

endmodule

// ===== dv/tb_led_pixel_scale_and_spi_encode_unit.sv =====
module tb_led_pixel_scale_and_spi_encode_unit;
   timeunit 1ns;
   timeprecision 1ps;
   import lpse_pkg::*;

   localparam int CYCLE_LIMIT     = 200000;
   localparam int DRAIN_CYCLES    = 8;
   localparam int RANDOM_PHASES   = 8;
   localparam int ITEMS_PER_PHASE = 26;
   localparam int HOLD_OFF_CYCLES = 300;

   localparam logic [CSR_INDEX_W-1:0] CSR_SPARE_INDEX_A = 2'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_SPARE_INDEX_B = 2'd3;

   logic                   clock;
   logic                   reset;
   logic                   csr_we;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0]  csr_wdata;
   int                     fail_count;
   int                     pending;
   int                     bytes_checked;

   int req_idle_pct  = 25;
   int rsp_idle_pct  = 25;
   int rsp_hold_left = 0;
   int cycle_count   = 0;
   int pixels_sent   = 0;
   int latches_sent  = 0;
   int settings_used = 1;

   lpse_req_if req_chan ();
   lpse_rsp_if rsp_chan ();

   led_pixel_scale_and_spi_encode_unit dut (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_chan),
      .rsp_chan  (rsp_chan),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   lpse_spi_byte_checker byte_check (
      .clock         (clock),
      .reset         (reset),
      .req_mon       (req_chan),
      .rsp_mon       (rsp_chan),
      .csr_we        (csr_we),
      .csr_index     (csr_index),
      .csr_wdata     (csr_wdata),
      .fail_count    (fail_count),
      .pending       (pending),
      .bytes_checked (bytes_checked)
   );

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("tb_led_pixel_scale_and_spi_encode_unit: FAIL");
         $finish;
      end
   end

   // receiver: random stalls, plus long hold-offs counted here
   initial begin
      rsp_chan.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (rsp_hold_left > 0) begin
            rsp_chan.ready <= 1'b0;
            rsp_hold_left--;
         end else begin
            rsp_chan.ready <= ($urandom_range(0, 99) >= rsp_idle_pct);
         end
      end
   end

   function automatic pixel_type pixel_of(input logic [7:0] pb, input logic [63:0] comps);
      pixel_type px;
      px.op               = OP_PIXEL;
      px.pixel_brightness = pb;
      px.comp             = comps;
      return px;
   endfunction

   function automatic pixel_type random_item();
      pixel_type px;
      px.op   = ($urandom_range(0, 7) == 0) ? OP_LATCH : OP_PIXEL;
      px.comp = {$urandom, $urandom};
      case ($urandom_range(0, 5))
         0: begin
            px.pixel_brightness = 8'd0;
         end
         1: begin
            px.pixel_brightness = 8'd255;
         end
         default: begin
            px.pixel_brightness = 8'($urandom);
         end
      endcase
      return px;
   endfunction

   function automatic logic [COUNT_W-1:0] random_count();
      case ($urandom_range(0, 9))
         0: begin
            return 4'd0;
         end
         1: begin
            return 4'($urandom_range(9, 15));
         end
         default: begin
            return 4'($urandom_range(1, 8));
         end
      endcase
   endfunction

   function automatic logic [7:0] random_brightness();
      case ($urandom_range(0, 4))
         0: begin
            return 8'd0;
         end
         1: begin
            return 8'd255;
         end
         default: begin
            return 8'($urandom);
         end
      endcase
   endfunction

   task automatic send_item(input pixel_type px);
      @(negedge clock);
      while ($urandom_range(0, 99) < req_idle_pct) begin
         req_chan.valid <= 1'b0;
         @(negedge clock);
      end
      req_chan.valid            <= 1'b1;
      req_chan.op               <= px.op;
      req_chan.pixel_brightness <= px.pixel_brightness;
      req_chan.component_0      <= px.comp[0];
      req_chan.component_1      <= px.comp[1];
      req_chan.component_2      <= px.comp[2];
      req_chan.component_3      <= px.comp[3];
      req_chan.component_4      <= px.comp[4];
      req_chan.component_5      <= px.comp[5];
      req_chan.component_6      <= px.comp[6];
      req_chan.component_7      <= px.comp[7];
      do @(posedge clock); while (!req_chan.ready);
      if (px.op == OP_LATCH) begin
         latches_sent++;
      end else begin
         pixels_sent++;
      end
   endtask

   task automatic wait_idle();
      @(negedge clock);
      req_chan.valid <= 1'b0;
      wait (pending == 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_csr(input logic [CSR_INDEX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] data);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(negedge clock);
      csr_we    <= 1'b0;
   endtask

   task automatic set_config(input logic [COUNT_W-1:0] count, input logic [7:0] brightness);
      wait_idle();
      // upper nibble is don't-care for the count register
      write_csr(CSR_COMPONENT_COUNT, {4'($urandom), count});
      write_csr(CSR_GLOBAL_BRIGHTNESS, brightness);
      settings_used++;
   endtask

   initial begin
      pixel_type px;
      reset                     = 1'b1;
      csr_we                    = 1'b0;
      csr_index                 = CSR_COMPONENT_COUNT;
      csr_wdata                 = '0;
      req_chan.valid            = 1'b0;
      req_chan.op               = OP_PIXEL;
      req_chan.pixel_brightness = '0;
      req_chan.component_0      = '0;
      req_chan.component_1      = '0;
      req_chan.component_2      = '0;
      req_chan.component_3      = '0;
      req_chan.component_4      = '0;
      req_chan.component_5      = '0;
      req_chan.component_6      = '0;
      req_chan.component_7      = '0;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // reset settings: three components, full brightness
      send_item(pixel_of(8'd255, {8{8'hFF}}));
      send_item(pixel_of(8'd255, {8{8'h00}}));
      send_item(pixel_of(8'd0, {8{8'hFF}}));
      send_item(pixel_of(8'd255, 64'h0000_0000_0055_0180));
      send_item(pixel_of(8'd254, 64'h0000_0000_007F_01FF));
      px    = random_item();
      px.op = OP_LATCH;
      send_item(px);

      // zero count acts as one component
      set_config(4'd0, 8'd255);
      send_item(pixel_of(8'd255, 64'hFFFF_FFFF_FFFF_FFA5));
      // counts above the maximum saturate
      set_config(4'd9, 8'd255);
      send_item(pixel_of(8'd255, 64'h8040_2010_0804_0201));
      set_config(4'd15, 8'd255);
      send_item(pixel_of(8'd200, {$urandom, $urandom}));
      set_config(4'd8, 8'd255);
      send_item(pixel_of(8'd255, 64'h0102_0408_1020_4080));
      px    = random_item();
      px.op = OP_LATCH;
      send_item(px);
      set_config(4'd1, 8'd255);
      send_item(pixel_of(8'd128, {$urandom, $urandom}));
      set_config(4'd3, 8'd0);
      send_item(pixel_of(8'd255, {8{8'hFF}}));
      set_config(4'd3, 8'd1);
      send_item(pixel_of(8'd255, {8{8'hFF}}));
      set_config(4'd4, 8'd128);
      send_item(pixel_of(8'd255, {8{8'hFF}}));
      send_item(pixel_of(8'd1, {8{8'hFF}}));
      // writes to unmapped indexes must leave both registers alone
      wait_idle();
      write_csr(CSR_SPARE_INDEX_A, 8'hFF);
      write_csr(CSR_SPARE_INDEX_B, 8'h00);
      send_item(pixel_of(8'd255, 64'h0000_0000_C3A5_5A3C));
      send_item(random_item());

      for (int p = 0; p < RANDOM_PHASES; p++) begin
         set_config(random_count(), random_brightness());
         if (p == 1) begin
            // back-pressure: sink holds off while the source keeps offering
            req_idle_pct  = 0;
            rsp_hold_left = HOLD_OFF_CYCLES;
         end else if (p == 2) begin
            req_idle_pct = 0;
            rsp_idle_pct = 0;
         end else begin
            req_idle_pct = 25;
            rsp_idle_pct = 25;
         end
         if (p == 5) begin
            write_csr(CSR_SPARE_INDEX_A, 8'($urandom));
         end
         repeat (ITEMS_PER_PHASE) begin
            send_item(random_item());
         end
      end

      wait_idle();
      repeat (2 * DRAIN_CYCLES) @(posedge clock);
      $display("Sent %0d pixels and %0d latches under %0d register settings,",
               pixels_sent, latches_sent, settings_used);
      $display("%0d SPI byte transactions checked, %0d failures", bytes_checked, fail_count);
      if (fail_count == 0 && pending == 0) begin
         $display("tb_led_pixel_scale_and_spi_encode_unit: PASS");
      end else begin
         $display("tb_led_pixel_scale_and_spi_encode_unit: FAIL");
      end
      $finish;
   end

endmodule
